// ===== hdl/sttgc_pkg.sv =====
// Shared types, constants and time helpers for the sorted time table.
package sttgc_pkg;

  localparam int ENTRY_W = 17;   // packed hours, minutes, seconds
  localparam int TOTAL_W = 17;   // seconds of day, raw or folded
  localparam int GAP_W   = 12;

  localparam logic [TOTAL_W-1:0] DAY_SECONDS  = 17'd86400;
  localparam logic [TOTAL_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TOTAL_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [GAP_W-1:0]   GAP_RESET    = 12'd60;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_UPDATE = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD      = 2'd1;
  localparam logic [1:0] ST_CONFLICT = 2'd2;

  typedef logic [ENTRY_W-1:0] entry_t;
  typedef logic [TOTAL_W-1:0] total_t;

  // Result of comparing one stored entry against the candidate time.
  typedef struct packed {
    logic conflict;  // closer than the gap, circularly
    logic ahead;     // entry sorts ahead of the candidate
  } cmp_res_t;

  // Raw seconds of day; fields are taken as stored, even out of range.
  function automatic total_t time_total(input entry_t e);
    time_total = TOTAL_W'(e[16:12]) * SEC_PER_HOUR
               + TOTAL_W'(e[11:6]) * SEC_PER_MIN
               + TOTAL_W'(e[5:0]);
  endfunction

  // Fold once into the day.
  function automatic total_t day_fold(input total_t t);
    day_fold = (t >= DAY_SECONDS) ? t - DAY_SECONDS : t;
  endfunction

endpackage

// ===== hdl/sorted_time_table_with_gap_check.sv =====
// Top level: sorted time-of-day table with circular gap check and sequencer.
//
//  Channel   Signals                                    Handshake
//  --------  -----------------------------------------  -------------------------
//  command   operation index hours minutes seconds      taken when start & !busy
//  result    status entry_count read_hours/minutes/sec  valid one cycle on done
//  config    min_gap_seconds                            written when min_gap_we
//
// A command runs under a small sequencer that drives one RAM port pair and one
// shared compare unit. Add and update scan all n entries, then move up to n
// entries one per cycle through the RAM, write the new time and raise done; a
// time conflict ends after the scan. Remove moves n - index - 1 entries, read
// waits for the registered RAM data, and rejects for a full table or bad index
// raise done straight from idle. Each move reads its source slot, then writes
// the registered data one slot over.
// Reset clears the entry count and loads a gap of 60 seconds; RAM contents
// are not cleared and are never used beyond the count. done pulses for one
// cycle and busy falls on the same edge; results cannot be held off.
module sorted_time_table_with_gap_check
  import sttgc_pkg::*;
#(
  parameter int CAPACITY = 12
) (
  input  logic                clk,
  input  logic                rst,
  // command
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          operation,
  input  logic [3:0]          index,
  input  logic [4:0]          hours,
  input  logic [5:0]          minutes,
  input  logic [5:0]          seconds,
  // result
  output logic                done,
  output logic [1:0]          status,
  output logic [3:0]          entry_count,
  output logic [4:0]          read_hours,
  output logic [5:0]          read_minutes,
  output logic [5:0]          read_seconds,
  // config
  input  logic                min_gap_we,
  input  logic [GAP_W-1:0]    min_gap_seconds
);

  localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > 4) ? CW : 4;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_SCAN      = 3'd1;
  localparam logic [2:0] S_SHIFT     = 3'd2;
  localparam logic [2:0] S_WRITE     = 3'd3;
  localparam logic [2:0] S_READ      = 3'd4;
  localparam logic [2:0] S_READ_WAIT = 3'd5;

  logic [2:0]       state;
  logic [GAP_W-1:0] gap;
  logic [CW-1:0]    count;

  // latched command
  logic [1:0]       op;
  logic [CW-1:0]    idx;
  entry_t           cand;
  total_t           cand_total;
  total_t           cand_day;

  // scan
  logic [CW-1:0]    issue_cnt;
  logic             rvalid;
  logic [AW-1:0]    raddr_q;
  logic             conflict;
  logic [CW-1:0]    pos;

  // move engine
  logic             up;
  logic [CW-1:0]    cur;
  logic [CW-1:0]    rem;
  logic             wpend;
  logic [AW-1:0]    wdest;

  // RAM and compare unit
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  entry_t           ram_wdata;
  logic [AW-1:0]    ram_raddr;
  entry_t           ram_rdata;
  cmp_res_t         cmp;
  logic             tie_before;

  logic             idx_ok;
  entry_t           new_entry;
  total_t           new_total;
  logic             scan_done;
  logic             skip;

  assign busy        = (state != S_IDLE);
  assign entry_count = 4'(count);
  assign idx_ok      = CMPW'(index) < CMPW'(count);
  assign new_entry   = {hours, minutes, seconds};
  assign new_total   = time_total(new_entry);
  assign scan_done   = (issue_cnt >= count) && !rvalid;
  assign skip        = (op == OP_UPDATE) && (CW'(raddr_q) == idx);
  assign tie_before  = (op == OP_ADD) || (CW'(raddr_q) < idx);

  sttgc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sttgc_cmp u_cmp (
    .entry      (ram_rdata),
    .cand_total (cand_total),
    .cand_day   (cand_day),
    .gap        (gap),
    .tie_before (tie_before),
    .res        (cmp)
  );

  // RAM port steering by sequencer state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wdest;
    ram_wdata = ram_rdata;
    ram_raddr = AW'(idx);
    unique case (state)
      S_SCAN: begin
        ram_raddr = AW'(issue_cnt);
      end
      S_SHIFT: begin
        ram_raddr = AW'(cur);
        ram_we    = wpend;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(pos);
        ram_wdata = cand;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap <= GAP_RESET;
    end else if (min_gap_we) begin
      gap <= min_gap_seconds;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      done     <= 1'b0;
      rvalid   <= 1'b0;
      wpend    <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            // latch the command and clear the per-item accumulators
            op           <= operation;
            idx          <= CW'(index);
            cand         <= new_entry;
            cand_total   <= new_total;
            cand_day     <= day_fold(new_total);
            issue_cnt    <= '0;
            rvalid       <= 1'b0;
            conflict     <= 1'b0;
            pos          <= '0;
            wpend        <= 1'b0;
            status       <= ST_BAD;
            read_hours   <= '0;
            read_minutes <= '0;
            read_seconds <= '0;
            unique case (operation)
              OP_ADD: begin
                if (count == CW'(CAPACITY)) begin
                  done <= 1'b1;
                end else begin
                  state <= S_SCAN;
                end
              end
              OP_UPDATE: begin
                if (idx_ok) begin
                  state <= S_SCAN;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_REMOVE: begin
                if (idx_ok) begin
                  // close the hole: move later entries down by one
                  up    <= 1'b0;
                  cur   <= CW'(index) + 1'b1;
                  rem   <= count - CW'(index) - 1'b1;
                  state <= S_SHIFT;
                end else begin
                  done <= 1'b1;
                end
              end
              OP_READ: begin
                if (idx_ok) begin
                  state <= S_READ;
                end else begin
                  done <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_SCAN: begin
          // issue one read per cycle, judge each returned entry once its registered read data is back
          rvalid <= 1'b0;
          if (issue_cnt < count) begin
            issue_cnt <= issue_cnt + 1'b1;
            rvalid    <= 1'b1;
            raddr_q   <= AW'(issue_cnt);
          end
          if (rvalid && !skip) begin
            if (cmp.conflict) begin
              conflict <= 1'b1;
            end
            if (cmp.ahead) begin
              pos <= pos + 1'b1;
            end
          end
          if (scan_done) begin
            if (conflict) begin
              status <= ST_CONFLICT;
              done   <= 1'b1;
              state  <= S_IDLE;
            end else begin
              state <= S_SHIFT;
              if (op == OP_ADD) begin
                up  <= 1'b1;
                cur <= count - 1'b1;
                rem <= count - pos;
              end else if (pos > idx) begin
                up  <= 1'b0;
                cur <= idx + 1'b1;
                rem <= pos - idx;
              end else begin
                up  <= 1'b1;
                cur <= idx - 1'b1;
                rem <= idx - pos;
              end
            end
          end
        end

        S_SHIFT: begin
          // read source now, write it one slot over on the next cycle
          if (rem != '0) begin
            wpend <= 1'b1;
            wdest <= up ? AW'(cur + 1'b1) : AW'(cur - 1'b1);
            cur   <= up ? cur - 1'b1 : cur + 1'b1;
            rem   <= rem - 1'b1;
          end else begin
            wpend <= 1'b0;
            if (!wpend) begin
              if (op == OP_REMOVE) begin
                count  <= count - 1'b1;
                status <= ST_OK;
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                state <= S_WRITE;
              end
            end
          end
        end

        S_WRITE: begin
          // new time lands at its sorted slot
          if (op == OP_ADD) begin
            count <= count + 1'b1;
          end
          status <= ST_OK;
          done   <= 1'b1;
          state  <= S_IDLE;
        end

        S_READ: begin
          state <= S_READ_WAIT;
        end

        S_READ_WAIT: begin
          status       <= ST_OK;
          read_hours   <= ram_rdata[16:12];
          read_minutes <= ram_rdata[11:6];
          read_seconds <= ram_rdata[5:0];
          done         <= 1'b1;
          state        <= S_IDLE;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/sttgc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module sttgc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 12,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/sttgc_cmp.sv =====
// Shared compare unit: circular gap check and sort-order test for one entry.
module sttgc_cmp
  import sttgc_pkg::*;
(
  input  entry_t             entry,
  input  total_t             cand_total,
  input  total_t             cand_day,
  input  logic [GAP_W-1:0]   gap,
  input  logic               tie_before,
  output cmp_res_t           res
);

  total_t key;
  total_t key_day;
  total_t dist_abs;
  total_t dist_wrap;
  total_t dist_min;

  always_comb begin
    key       = time_total(entry);
    key_day   = day_fold(key);
    dist_abs  = (cand_day > key_day) ? cand_day - key_day : key_day - cand_day;
    dist_wrap = DAY_SECONDS - dist_abs;
    dist_min  = (dist_wrap < dist_abs) ? dist_wrap : dist_abs;
    res.conflict = dist_min < TOTAL_W'(gap);
    // equal keys keep their prior order relative to the candidate
    res.ahead    = (key < cand_total) || ((key == cand_total) && tie_before);
  end

endmodule

// ===== bench/time_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the sorted time table: mirrors the table, predicts each reply, compares.
module time_table_checker
  import sttgc_pkg::*;
#(
  parameter int CAPACITY = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [1:0]        operation,
  input  logic [3:0]        index,
  input  logic [4:0]        hours,
  input  logic [5:0]        minutes,
  input  logic [5:0]        seconds,
  input  logic              done,
  input  logic [1:0]        status,
  input  logic [3:0]        entry_count,
  input  logic [4:0]        read_hours,
  input  logic [5:0]        read_minutes,
  input  logic [5:0]        read_seconds,
  input  logic              min_gap_we,
  input  logic [GAP_W-1:0]  min_gap_seconds,
  output int unsigned       fail_count,
  output int unsigned       pending
);

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] count;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
  } reply_t;

  entry_t           slots [CAPACITY];
  int unsigned      used = 0;
  logic [GAP_W-1:0] gap = GAP_RESET;
  reply_t           replies_due [$];
  int unsigned      mismatches = 0;

  function automatic int unsigned folded_secs(entry_t e);
    int unsigned raw;
    raw = int'(e[16:12]) * 3600 + int'(e[11:6]) * 60 + int'(e[5:0]);
    return (raw >= 86400) ? raw - 86400 : raw;
  endfunction

  function automatic int unsigned raw_secs(entry_t e);
    return int'(e[16:12]) * 3600 + int'(e[11:6]) * 60 + int'(e[5:0]);
  endfunction

  // True when cand keeps the gap, around midnight too, to every entry but the skipped one.
  function automatic bit keeps_gap(entry_t cand, bit skip_one, int unsigned skip_at);
    int unsigned a, b, d;
    a = folded_secs(cand);
    for (int unsigned i = 0; i < used; i++) begin
      if (skip_one && i == skip_at) continue;
      b = folded_secs(slots[i]);
      d = (a > b) ? a - b : b - a;
      if (86400 - d < d) d = 86400 - d;
      if (d < gap) return 0;
    end
    return 1;
  endfunction

  // Stable bubble pass: equal totals keep their order.
  function automatic void resort();
    entry_t t;
    for (int unsigned i = 0; i < used; i++) begin
      for (int unsigned j = 0; j + 1 < used - i; j++) begin
        if (raw_secs(slots[j]) > raw_secs(slots[j + 1])) begin
          t = slots[j];
          slots[j] = slots[j + 1];
          slots[j + 1] = t;
        end
      end
    end
  endfunction

  function automatic reply_t apply_command(logic [1:0] op, logic [3:0] idx, entry_t cand);
    reply_t r;
    bit     idx_ok;
    r = '0;
    idx_ok = int'(idx) < used;
    case (op)
      OP_ADD: begin
        if (used >= CAPACITY) r.status = ST_BAD;
        else if (!keeps_gap(cand, 0, 0)) r.status = ST_CONFLICT;
        else begin
          slots[used] = cand;
          used++;
          resort();
        end
      end
      OP_UPDATE: begin
        if (!idx_ok) r.status = ST_BAD;
        else if (!keeps_gap(cand, 1, idx)) r.status = ST_CONFLICT;
        else begin
          slots[idx] = cand;
          resort();
        end
      end
      OP_REMOVE: begin
        if (!idx_ok) r.status = ST_BAD;
        else begin
          for (int unsigned i = idx; i + 1 < used; i++) slots[i] = slots[i + 1];
          used--;
        end
      end
      OP_READ: begin
        if (!idx_ok) r.status = ST_BAD;
        else {r.hours, r.minutes, r.seconds} = slots[idx];
      end
    endcase
    r.count = used[3:0];
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t got, want;
    if (rst) begin
      used = 0;
      gap = GAP_RESET;
      replies_due.delete();
    end else begin
      // Results first: a new item may be taken on the edge that ends a result.
      if (done) begin
        got = '{status, entry_count, read_hours, read_minutes, read_seconds};
        if (replies_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with nothing expected: status %0d count %0d", $time,
                     got.status, got.count);
          mismatches++;
        end else begin
          want = replies_due.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: expected status %0d count %0d time %0d:%0d:%0d, got %0d %0d %0d:%0d:%0d",
                       $time, want.status, want.count, want.hours, want.minutes, want.seconds,
                       got.status, got.count, got.hours, got.minutes, got.seconds);
            mismatches++;
          end
        end
      end
      if (min_gap_we) gap = min_gap_seconds;
      if (start && !busy)
        replies_due.push_back(apply_command(operation, index, {hours, minutes, seconds}));
    end
    pending <= replies_due.size();
    fail_count <= mismatches;
  end

endmodule

// ===== bench/sorted_time_table_with_gap_check_test.sv =====
`timescale 1ns / 1ps
// Testbench top for the sorted time table: stimulus, watchdog and verdict.
module sorted_time_table_with_gap_check_test
  import sttgc_pkg::*;
();

  localparam int CAPACITY      = 12;
  localparam int STALL_LIMIT   = 2000;  // cycles with no item and no result taken
  localparam int SETTLE_CYCLES = 40;    // longer than the slowest add
  localparam int PHASE_ITEMS   = 142;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       operation = OP_ADD;
  logic [3:0]       index = '0;
  logic [4:0]       hours = '0;
  logic [5:0]       minutes = '0;
  logic [5:0]       seconds = '0;
  logic             min_gap_we = 1'b0;
  logic [GAP_W-1:0] min_gap_seconds = GAP_RESET;

  logic             busy, done;
  logic [1:0]       status;
  logic [3:0]       entry_count;
  logic [4:0]       read_hours;
  logic [5:0]       read_minutes;
  logic [5:0]       read_seconds;

  int unsigned      fail_count, pending;
  int unsigned      idle_pct = 0;
  logic [3:0]       seen_count = '0;  // last entry count reported, steers the operation mix

  always #6 clk = ~clk;

  sorted_time_table_with_gap_check #(.CAPACITY(CAPACITY)) i_dut (
    .clk, .rst, .start, .busy, .operation, .index, .hours, .minutes, .seconds,
    .done, .status, .entry_count, .read_hours, .read_minutes, .read_seconds,
    .min_gap_we, .min_gap_seconds
  );

  time_table_checker #(.CAPACITY(CAPACITY)) i_check (
    .clk, .rst, .start, .busy, .operation, .index, .hours, .minutes, .seconds,
    .done, .status, .entry_count, .read_hours, .read_minutes, .read_seconds,
    .min_gap_we, .min_gap_seconds, .fail_count, .pending
  );

  always @(posedge clk) if (done) seen_count <= entry_count;

  // Offer one item from a falling edge, hold it until taken, return on the next
  // falling edge with start still high so back-to-back items need no extra step.
  task automatic issue(input logic [1:0] op, input logic [3:0] idx, input entry_t t);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    operation <= op;
    index <= idx;
    {hours, minutes, seconds} <= t;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  // Drop start, drain every pending result, then write the gap register.
  task automatic set_gap(input logic [GAP_W-1:0] g);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    min_gap_we <= 1'b1;
    min_gap_seconds <= g;
    @(negedge clk);
    min_gap_we <= 1'b0;
  endtask

  // Mostly legal times; some raw bit patterns and some from a small pool that
  // collides on purpose (equal totals, both sides of midnight).
  function automatic entry_t pick_time();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return entry_t'($urandom);
    if (r < 20) begin
      case ($urandom_range(5))
        0: return {5'd1, 6'd0, 6'd0};
        1: return {5'd0, 6'd60, 6'd0};   // same total as 01:00:00
        2: return {5'd0, 6'd0, 6'd0};
        3: return {5'd23, 6'd59, 6'd59};
        4: return {5'd12, 6'd0, 6'd0};
        default: return {5'd11, 6'd59, 6'd60};  // same total as 12:00:00
      endcase
    end
    return {5'($urandom_range(23)), 6'($urandom_range(59)), 6'($urandom_range(59))};
  endfunction

  // Watchdog: end the run if nothing moves for too long.
  initial begin
    int unsigned stalled;
    stalled = 0;
    while (stalled < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) stalled = 0;
      else stalled++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    logic [GAP_W-1:0] gaps [6];
    logic [1:0]       op;
    logic [3:0]       idx;
    int unsigned      n, r;

    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part, reset gap of 60 seconds.
    issue(OP_READ,   4'd0,  '0);                        // empty table, bad index
    issue(OP_UPDATE, 4'd0,  {5'd5, 6'd5, 6'd5});        // empty table, bad index
    issue(OP_ADD,    4'd15, {5'd0, 6'd0, 6'd0});        // lowest time
    issue(OP_ADD,    4'd0,  {5'd23, 6'd59, 6'd30});     // 30 s across midnight: conflict
    issue(OP_ADD,    4'd0,  {5'd23, 6'd59, 6'd0});      // exactly the gap: accepted
    issue(OP_ADD,    4'd0,  {5'd0, 6'd0, 6'd59});       // 59 s away: conflict
    issue(OP_ADD,    4'd0,  {5'd31, 6'd63, 6'd63});     // out-of-range fields, stored raw
    issue(OP_READ,   4'd1,  '0);
    issue(OP_READ,   4'd2,  '0);
    issue(OP_UPDATE, 4'd0,  {5'd0, 6'd0, 6'd30});       // replaced entry is not checked
    issue(OP_UPDATE, 4'd0,  {5'd23, 6'd59, 6'd30});     // conflicts with 23:59:00
    for (int k = 0; k < 9; k++)
      issue(OP_ADD, 4'(k), {5'(2 * k + 3), 6'd0, 6'd0}); // fill to capacity
    issue(OP_ADD,    4'd0,  {5'd21, 6'd0, 6'd0});       // full table
    issue(OP_UPDATE, 4'd11, {5'd22, 6'd0, 6'd0});
    issue(OP_REMOVE, 4'd11, '0);                        // last entry
    issue(OP_REMOVE, 4'd0,  '0);                        // first entry, rest move down
    issue(OP_REMOVE, 4'd15, '0);                        // bad index

    // Zero gap: equal totals keep arrival order.
    set_gap('0);
    issue(OP_ADD,  4'd0, {5'd1, 6'd0, 6'd0});
    issue(OP_ADD,  4'd0, {5'd0, 6'd60, 6'd0});
    issue(OP_READ, 4'd0, '0);
    issue(OP_READ, 4'd1, '0);

    // Random phases, each under its own gap; idling is light, then heavy, then off.
    gaps[0] = GAP_W'(3600);
    gaps[1] = GAP_W'($urandom_range(1, 600));
    gaps[2] = '0;
    gaps[3] = GAP_W'($urandom_range(0, 3600));
    gaps[4] = GAP_RESET;
    gaps[5] = GAP_W'($urandom_range(1, 3600));
    for (int p = 0; p < 6; p++) begin
      set_gap(gaps[p]);
      idle_pct = (p < 2) ? 21 : (p < 4) ? 67 : 0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        n = seen_count;
        r = $urandom_range(99);
        // Favor adds on a thin table and removes on a crowded one.
        if (n < 4)
          op = (r < 60) ? OP_ADD : (r < 75) ? OP_UPDATE : (r < 85) ? OP_REMOVE : OP_READ;
        else if (n >= 10)
          op = (r < 25) ? OP_ADD : (r < 50) ? OP_UPDATE : (r < 80) ? OP_REMOVE : OP_READ;
        else
          op = (r < 40) ? OP_ADD : (r < 60) ? OP_UPDATE : (r < 75) ? OP_REMOVE : OP_READ;
        if (n == 0 || $urandom_range(99) < 15) idx = 4'($urandom_range(15));
        else idx = 4'($urandom_range(n - 1));
        issue(op, idx, pick_time());
      end
    end

    // Drain, let the block settle, then give the verdict.
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/sttgc_pkg.sv
hdl/sttgc_ram.sv
hdl/sttgc_cmp.sv
hdl/sorted_time_table_with_gap_check.sv
bench/time_table_checker.sv
bench/sorted_time_table_with_gap_check_test.sv
